// File: sv/nfhe_pkg.sv
package nfhe_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_PEER  = 2'd0,
        MODE_QUEUE = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Peer line kinds
    typedef enum logic [1:0] {
        LK_STATUS = 2'd0,
        LK_BLANK  = 2'd1,
        LK_TEXT   = 2'd2,
        LK_NODATA = 2'd3
    } line_kind_t;

    // Result actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_MODE_STR = 3'd1;
    localparam logic [2:0] ACT_WHAT     = 3'd2;
    localparam logic [2:0] ACT_CHECK    = 3'd3;
    localparam logic [2:0] ACT_XCHECK   = 3'd4;
    localparam logic [2:0] ACT_DISC     = 3'd5;

    // Result warnings
    localparam logic [2:0] WRN_NONE     = 3'd0;
    localparam logic [2:0] WRN_HELLO    = 3'd1;
    localparam logic [2:0] WRN_ODD_MODE = 3'd2;
    localparam logic [2:0] WRN_BAD_MODE = 3'd3;
    localparam logic [2:0] WRN_DELAYED  = 3'd4;
    localparam logic [2:0] WRN_DENIED   = 3'd5;
    localparam logic [2:0] WRN_BAD_FEED = 3'd6;
    localparam logic [2:0] WRN_BLANK    = 3'd7;

    // Peer status codes
    localparam logic [9:0] CODE_200 = 10'd200;
    localparam logic [9:0] CODE_203 = 10'd203;
    localparam logic [9:0] CODE_238 = 10'd238;
    localparam logic [9:0] CODE_239 = 10'd239;
    localparam logic [9:0] CODE_299 = 10'd299;
    localparam logic [9:0] CODE_400 = 10'd400;
    localparam logic [9:0] CODE_431 = 10'd431;
    localparam logic [9:0] CODE_438 = 10'd438;
    localparam logic [9:0] CODE_439 = 10'd439;
    localparam logic [9:0] CODE_480 = 10'd480;
    localparam logic [9:0] CODE_500 = 10'd500;
    localparam logic [9:0] CODE_599 = 10'd599;

    // Configuration register index (word select bit of paddr)
    localparam logic REG_MAX_QUEUE = 1'b0;
    localparam logic [5:0] MAX_QUEUE_RESET = 6'd63;

    // Handshake states
    typedef enum logic [1:0] {
        HS_HELLO = 2'd0,
        HS_MODE  = 2'd1,
        HS_CHECK = 2'd2,
        HS_FEED  = 2'd3
    } hs_state_t;

    // Back end states
    typedef enum logic [1:0] {
        BK_IDLE    = 2'd0,
        BK_FL_RD   = 2'd1,
        BK_FL_EMIT = 2'd2
    } bk_state_t;

    // Command from front to back
    typedef enum logic [1:0] {
        CMD_PEER  = 2'd0,
        CMD_QUEUE = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [2:0] action;
        logic [2:0] warning;
        logic       io_err;
        logic       clear;
        logic       stream;
    } cmd_t;

endpackage

// File: sv/nfhe_front.sv
module nfhe_front
    import nfhe_pkg::*;
#(
    parameter int HANDLE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    fifo_full,
    input  logic [1:0]              mode,
    input  logic [1:0]              line_kind,
    input  logic [9:0]              status_code,
    input  logic                    read_timeout,
    input  logic                    read_error,
    input  logic [HANDLE_WIDTH-1:0] article_in,
    output logic                    in_stall,
    output logic                    cmd_push,
    output cmd_t                    cmd,
    output logic [HANDLE_WIDTH-1:0] cmd_handle
);

    hs_state_t hs_reg, hs_next;
    logic      ext_reg, ext_next;
    logic      stream_reg, stream_next;
    logic      accept;
    logic      is_peer;
    logic      disc;
    logic      class2;
    logic      class5;

    assign in_stall   = fifo_full;
    assign accept     = in_valid && !fifo_full;
    assign is_peer    = (mode_t'(mode) == MODE_PEER);
    assign disc       = read_timeout || (line_kind_t'(line_kind) == LK_NODATA);
    assign class2     = status_code inside {[CODE_200:CODE_299]};
    assign class5     = status_code inside {[CODE_500:CODE_599]};
    assign cmd_handle = article_in;

    // Advance handshake state and peer flags
    always_comb
    begin
        hs_next     = hs_reg;
        ext_next    = ext_reg;
        stream_next = stream_reg;
        if (accept && is_peer)
        begin
            if (disc)
            begin
                hs_next     = HS_HELLO;
                ext_next    = 1'b0;
                stream_next = 1'b0;
            end
            else if (line_kind_t'(line_kind) == LK_STATUS)
            begin
                case (hs_reg)
                    HS_HELLO:
                    begin
                        if (status_code == CODE_200)
                        begin
                            hs_next = HS_MODE;
                        end
                    end
                    HS_MODE:
                    begin
                        hs_next     = HS_CHECK;
                        stream_next = class2;
                    end
                    default:
                    begin
                        hs_next = HS_FEED;
                        if (status_code == CODE_238)
                        begin
                            ext_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Classify the transaction into a command
    always_comb
    begin
        cmd_push    = accept && (mode_t'(mode) != MODE_NONE);
        cmd.op      = CMD_PEER;
        cmd.action  = ACT_NONE;
        cmd.warning = WRN_NONE;
        cmd.io_err  = read_error && !read_timeout;
        cmd.clear   = 1'b0;
        cmd.stream  = stream_reg;
        case (mode_t'(mode))
            MODE_QUEUE:
            begin
                cmd.op = CMD_QUEUE;
            end
            MODE_FLUSH:
            begin
                cmd.op     = CMD_FLUSH;
                cmd.io_err = 1'b0;
                cmd.action = ext_reg ? ACT_XCHECK : ACT_CHECK;
            end
            default:
            begin
                if (disc)
                begin
                    cmd.action = ACT_DISC;
                    cmd.clear  = 1'b1;
                end
                else if (line_kind_t'(line_kind) == LK_BLANK)
                begin
                    cmd.warning = WRN_BLANK;
                end
                else if (line_kind_t'(line_kind) == LK_TEXT)
                begin
                    cmd.action = ACT_WHAT;
                end
                else
                begin
                    case (hs_reg)
                        HS_HELLO:
                        begin
                            if (status_code == CODE_200)
                            begin
                                cmd.action = ACT_MODE_STR;
                            end
                            else
                            begin
                                cmd.warning = WRN_HELLO;
                            end
                        end
                        HS_MODE:
                        begin
                            if (class2)
                            begin
                                if (status_code != CODE_203)
                                begin
                                    cmd.warning = WRN_ODD_MODE;
                                end
                            end
                            else if (status_code != CODE_500)
                            begin
                                cmd.warning = WRN_BAD_MODE;
                            end
                        end
                        default:
                        begin
                            if (status_code inside {CODE_238, CODE_239, CODE_438})
                            begin
                                cmd.warning = WRN_NONE;
                            end
                            else if (status_code inside {CODE_400, CODE_431, CODE_439})
                            begin
                                cmd.warning = WRN_DELAYED;
                            end
                            else if (status_code == CODE_480)
                            begin
                                cmd.warning = WRN_DENIED;
                            end
                            else if (!class5)
                            begin
                                cmd.warning = WRN_BAD_FEED;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // Hold handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg     <= HS_HELLO;
            ext_reg    <= 1'b0;
            stream_reg <= 1'b0;
        end
        else
        begin
            hs_reg     <= hs_next;
            ext_reg    <= ext_next;
            stream_reg <= stream_next;
        end
    end

endmodule

// File: sv/nfhe_cmd_fifo.sv
module nfhe_cmd_fifo
    import nfhe_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command pushed into full queue");

endmodule

// File: sv/nfhe_back.sv
module nfhe_back
    import nfhe_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 64,
    parameter int HANDLE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [5:0]              max_queue,
    input  logic                    cmd_empty,
    input  cmd_t                    cmd,
    input  logic [HANDLE_WIDTH-1:0] cmd_handle,
    output logic                    cmd_pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              action,
    output logic [HANDLE_WIDTH-1:0] article_out,
    output logic [2:0]              warning,
    output logic                    io_error_seen,
    output logic                    last
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    logic [HANDLE_WIDTH-1:0] ring_mem [QUEUE_DEPTH];
    logic [HANDLE_WIDTH-1:0] rd_data_reg;

    bk_state_t               state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [2:0]              fl_action_reg, fl_action_next;
    logic                    fl_stream_reg, fl_stream_next;

    logic                    out_valid_reg, out_valid_next;
    logic [2:0]              action_reg, action_next;
    logic [HANDLE_WIDTH-1:0] article_reg, article_next;
    logic [2:0]              warning_reg, warning_next;
    logic                    ioerr_reg, ioerr_next;
    logic                    last_reg, last_next;

    logic                    out_free;
    logic                    load_peer;
    logic                    mem_we;
    logic                    start_flush;
    logic                    emit;
    logic                    fin;
    logic                    drop;
    logic [IDX_W-1:0]        head_inc;
    logic [SUM_W-1:0]        wr_sum;
    logic [SUM_W-1:0]        wr_wrap;
    logic [IDX_W-1:0]        wr_addr;

    assign out_free = !out_valid_reg || !out_stall;
    assign fin      = (count_reg == CNT_W'(1)) || !fl_stream_reg;
    assign drop     = (CMP_W'(count_reg) > CMP_W'(max_queue))
                      || (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign wr_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign wr_wrap  = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ? wr_sum - SUM_W'(QUEUE_DEPTH)
                                                      : wr_sum;
    assign wr_addr  = wr_wrap[IDX_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && (cmd.op == CMD_FLUSH) && (count_reg != '0))
                begin
                    state_next = BK_FL_RD;
                end
            end
            BK_FL_RD:
            begin
                state_next = BK_FL_EMIT;
            end
            BK_FL_EMIT:
            begin
                if (out_free && fin)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        cmd_pop     = 1'b0;
        load_peer   = 1'b0;
        mem_we      = 1'b0;
        start_flush = 1'b0;
        emit        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    case (cmd.op)
                        CMD_PEER:
                        begin
                            load_peer = out_free;
                            cmd_pop   = out_free;
                        end
                        CMD_QUEUE:
                        begin
                            mem_we  = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        default:
                        begin
                            cmd_pop     = 1'b1;
                            start_flush = (count_reg != '0);
                        end
                    endcase
                end
            end
            BK_FL_EMIT:
            begin
                emit = out_free;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Advance ring pointers and flush context
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        fl_action_next = fl_action_reg;
        fl_stream_next = fl_stream_reg;
        if (load_peer && cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (mem_we)
        begin
            if (drop)
            begin
                head_next = head_inc;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (emit)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        if (start_flush)
        begin
            fl_action_next = cmd.action;
            fl_stream_next = cmd.stream;
        end
    end

    // Load the output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        action_next    = action_reg;
        article_next   = article_reg;
        warning_next   = warning_reg;
        ioerr_next     = ioerr_reg;
        last_next      = last_reg;
        if (load_peer)
        begin
            out_valid_next = 1'b1;
            action_next    = cmd.action;
            article_next   = '0;
            warning_next   = cmd.warning;
            ioerr_next     = cmd.io_err;
            last_next      = 1'b1;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            action_next    = fl_action_reg;
            article_next   = rd_data_reg;
            warning_next   = WRN_NONE;
            ioerr_next     = 1'b0;
            last_next      = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            fl_action_reg <= ACT_CHECK;
            fl_stream_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fl_action_reg <= fl_action_next;
            fl_stream_reg <= fl_stream_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        article_reg <= article_next;
        warning_reg <= warning_next;
        ioerr_reg   <= ioerr_next;
        last_reg    <= last_next;
    end

    // Ring memory: one write port, registered read at the upcoming head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_addr] <= cmd_handle;
        end
        rd_data_reg <= ring_mem[head_next];
    end

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign article_out   = article_reg;
    assign warning       = warning_reg;
    assign io_error_seen = ioerr_reg;
    assign last          = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ring count above depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FL_EMIT) |-> (count_reg != '0))
        else $error("flush emitting from empty ring");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (load_peer && cmd.clear) |=> (count_reg == '0) && (head_reg == '0))
        else $error("disconnect did not clear ring");

endmodule

// File: sv/news_feed_handshake_engine.sv
// Channel   Handshake                         Payload
// input     in_valid / in_stall               mode line_kind status_code read_timeout
//                                             read_error article_in
// output    out_valid / out_stall             action article_out warning io_error_seen last
// config    psel penable pwrite pready        paddr pwdata prdata (max_queue at byte 0)
//
// A peer line result passes from the command queue into the output register once it is free;
// a queued article reaches the ring when its command is popped and gives no result.
// A flush pops its command, reads the ring head in BK_FL_RD and loads its first result
// in BK_FL_EMIT, then one entry per cycle while out_stall is low.
// Reset clears handshake state, ring head and count; ring contents stay undefined.
// in_stall rises only while the command queue is full; out_stall holds the output register.
module news_feed_handshake_engine
    import nfhe_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 64,
    parameter int HANDLE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [1:0]              line_kind,
    input  logic [9:0]              status_code,
    input  logic                    read_timeout,
    input  logic                    read_error,
    input  logic [HANDLE_WIDTH-1:0] article_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              action,
    output logic [HANDLE_WIDTH-1:0] article_out,
    output logic [2:0]              warning,
    output logic                    io_error_seen,
    output logic                    last
);

    localparam int CMD_W  = $bits(cmd_t);
    localparam int FIFO_W = CMD_W + HANDLE_WIDTH;

    logic [5:0]              max_queue_reg, max_queue_next;
    logic                    cfg_wr;
    logic                    cmd_push;
    logic                    cmd_pop;
    logic                    fifo_full;
    logic                    fifo_empty;
    cmd_t                    front_cmd;
    cmd_t                    back_cmd;
    logic [HANDLE_WIDTH-1:0] front_handle;
    logic [HANDLE_WIDTH-1:0] back_handle;
    logic [FIFO_W-1:0]       fifo_wr_data;
    logic [FIFO_W-1:0]       fifo_rd_data;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_QUEUE);

    always_comb
    begin
        max_queue_next = max_queue_reg;
        if (cfg_wr)
        begin
            max_queue_next = pwdata[5:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_QUEUE)
        begin
            prdata = {26'd0, max_queue_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_queue_reg <= MAX_QUEUE_RESET;
        end
        else
        begin
            max_queue_reg <= max_queue_next;
        end
    end

    // Front end: accept and classify
    nfhe_front #(
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .fifo_full    (fifo_full),
        .mode         (mode),
        .line_kind    (line_kind),
        .status_code  (status_code),
        .read_timeout (read_timeout),
        .read_error   (read_error),
        .article_in   (article_in),
        .in_stall     (in_stall),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd),
        .cmd_handle   (front_handle)
    );

    // Command queue
    assign fifo_wr_data = {front_cmd, front_handle};
    assign back_cmd     = cmd_t'(fifo_rd_data[FIFO_W-1:HANDLE_WIDTH]);
    assign back_handle  = fifo_rd_data[HANDLE_WIDTH-1:0];

    nfhe_cmd_fifo #(
        .DATA_W (FIFO_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (fifo_wr_data),
        .pop     (cmd_pop),
        .rd_data (fifo_rd_data),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // Back end: ring and result generation
    nfhe_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_queue     (max_queue_reg),
        .cmd_empty     (fifo_empty),
        .cmd           (back_cmd),
        .cmd_handle    (back_handle),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .article_out   (article_out),
        .warning       (warning),
        .io_error_seen (io_error_seen),
        .last          (last)
    );

endmodule

// File: tb/tb.sv
module tb
    import nfhe_pkg::*;
();

    localparam int HW          = 32;
    localparam int RING_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 195;
    localparam int QUIET_ITEMS = 40;
    localparam int CFG_EVERY   = 50;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam logic [2:0] MAX_QUEUE_ADDR = {REG_MAX_QUEUE, 2'b00};

    typedef struct {
        mode_t      op;
        line_kind_t kind;
        logic [9:0] code;
        logic       tmo;
        logic       rerr;
        logic [HW-1:0] art;
    } feed_item_t;

    typedef struct {
        logic [2:0]    act;
        logic [HW-1:0] art;
        logic [2:0]    warn;
        logic          ioerr;
        logic          fin;
    } feed_result_t;

    // Link model: handshake progress, flags and the article ring
    class feed_scoreboard;
        hs_state_t     hs;
        bit            xcheck_ok;
        bit            stream_ok;
        logic [HW-1:0] ring [RING_DEPTH];
        bit [5:0]      head;
        int            count;
        bit [5:0]      max_queue;
        feed_result_t  due_results[$];
        int            errors;

        function new();
            max_queue = MAX_QUEUE_RESET;
            errors = 0;
            clear_link();
        endfunction

        function void clear_link();
            hs = HS_HELLO;
            xcheck_ok = 1'b0;
            stream_ok = 1'b0;
            head = '0;
            count = 0;
        endfunction

        function logic [HW-1:0] pop_oldest();
            logic [HW-1:0] h;
            h = ring[head];
            head = head + 6'd1;
            count--;
            return h;
        endfunction

        // Append one predicted result
        function void add_due(feed_result_t r);
            due_results = {due_results, r};
        endfunction

        // Take the oldest predicted result
        function feed_result_t take_due();
            feed_result_t r;
            r = due_results[0];
            due_results.delete(0);
            return r;
        endfunction

        // Predict the results of one accepted transaction
        function void note_item(feed_item_t it);
            feed_result_t r;
            r = '{act: ACT_NONE, art: '0, warn: WRN_NONE, ioerr: 1'b0, fin: 1'b1};
            case (it.op)
                MODE_PEER:
                begin
                    r.ioerr = it.rerr && !it.tmo;
                    if (it.tmo || it.kind == LK_NODATA)
                    begin
                        clear_link();
                        r.act = ACT_DISC;
                    end
                    else if (it.kind == LK_BLANK)
                        r.warn = WRN_BLANK;
                    else if (it.kind == LK_TEXT)
                        r.act = ACT_WHAT;
                    else if (hs == HS_HELLO)
                    begin
                        if (it.code == CODE_200)
                        begin
                            hs = HS_MODE;
                            r.act = ACT_MODE_STR;
                        end
                        else
                            r.warn = WRN_HELLO;
                    end
                    else if (hs == HS_MODE)
                    begin
                        hs = HS_CHECK;
                        stream_ok = (it.code >= CODE_200 && it.code <= CODE_299);
                        if (stream_ok)
                        begin
                            if (it.code != CODE_203)
                                r.warn = WRN_ODD_MODE;
                        end
                        else if (it.code != CODE_500)
                            r.warn = WRN_BAD_MODE;
                    end
                    else
                    begin
                        hs = HS_FEED;
                        if (it.code == CODE_238)
                            xcheck_ok = 1'b1;
                        else if (it.code == CODE_239 || it.code == CODE_438)
                            r.warn = WRN_NONE;
                        else if (it.code == CODE_400 || it.code == CODE_431 ||
                                 it.code == CODE_439)
                            r.warn = WRN_DELAYED;
                        else if (it.code == CODE_480)
                            r.warn = WRN_DENIED;
                        else if (!(it.code >= CODE_500 && it.code <= CODE_599))
                            r.warn = WRN_BAD_FEED;
                    end
                    add_due(r);
                end
                MODE_QUEUE:
                begin
                    // drop the oldest entry when over the limit or full
                    if (count > max_queue || count >= RING_DEPTH)
                        void'(pop_oldest());
                    ring[6'(head + count)] = it.art;
                    count++;
                end
                MODE_FLUSH:
                begin
                    r.act = xcheck_ok ? ACT_XCHECK : ACT_CHECK;
                    while (count > 0)
                    begin
                        r.art = pop_oldest();
                        r.fin = (count == 0) || !stream_ok;
                        add_due(r);
                        if (r.fin)
                            break;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [HW-1:0] exp_v, logic [HW-1:0] got_v);
            if (got_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Compare one result against the oldest prediction
        function void check_result(feed_result_t got);
            feed_result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, got action %0d article %0h",
                         $time, got.act, got.art);
                errors++;
                return;
            end
            want = take_due();
            compare_field("action", HW'(want.act), HW'(got.act));
            compare_field("article_out", want.art, got.art);
            compare_field("warning", HW'(want.warn), HW'(got.warn));
            compare_field("io_error_seen", HW'(want.ioerr), HW'(got.ioerr));
            compare_field("last", HW'(want.fin), HW'(got.fin));
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          in_valid;
    logic          in_stall;
    logic [1:0]    mode;
    logic [1:0]    line_kind;
    logic [9:0]    status_code;
    logic          read_timeout;
    logic          read_error;
    logic [HW-1:0] article_in;
    logic          out_valid;
    logic          out_stall;
    logic [2:0]    action;
    logic [HW-1:0] article_out;
    logic [2:0]    warning;
    logic          io_error_seen;
    logic          last;

    feed_scoreboard sb = new();
    bit quiet = 1'b0;
    int gap_pct = 0;
    int sent = 0;
    int cycles = 0;

    news_feed_handshake_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .line_kind     (line_kind),
        .status_code   (status_code),
        .read_timeout  (read_timeout),
        .read_error    (read_error),
        .article_in    (article_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .article_out   (article_out),
        .warning       (warning),
        .io_error_seen (io_error_seen),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("news_feed_handshake_engine regression: fail");
            $finish;
        end
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result('{act: action, art: article_out, warn: warning,
                              ioerr: io_error_seen, fin: last});
    end

    // Stall the result side in random bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    function automatic feed_item_t mk_peer(line_kind_t kind, logic [9:0] code,
                                           logic tmo, logic rerr);
        return '{op: MODE_PEER, kind: kind, code: code, tmo: tmo, rerr: rerr,
                 art: $urandom};
    endfunction

    function automatic feed_item_t mk_other(mode_t op, logic [HW-1:0] art);
        return '{op: op, kind: line_kind_t'($urandom_range(0, 3)),
                 code: 10'($urandom_range(0, 1023)), tmo: 1'($urandom),
                 rerr: 1'($urandom), art: art};
    endfunction

    function automatic logic [9:0] pick_mode_code();
        case ($urandom_range(0, 3))
            0: return CODE_203;
            1: return 10'($urandom_range(CODE_200, CODE_299));
            2: return CODE_500;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [9:0] pick_feed_code();
        case ($urandom_range(0, 9))
            0: return CODE_238;
            1: return CODE_239;
            2: return CODE_438;
            3: return CODE_400;
            4: return CODE_431;
            5: return CODE_439;
            6: return CODE_480;
            7: return 10'($urandom_range(CODE_500, CODE_599));
            8: return 10'($urandom_range(1000, 1023));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Drive one transaction and wait for its acceptance
    task automatic send_item(input feed_item_t it);
        if (!quiet && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= it.op;
        line_kind    <= it.kind;
        status_code  <= it.code;
        read_timeout <= it.tmo;
        read_error   <= it.rerr;
        article_in   <= it.art;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
        if (it.op != MODE_NONE)
            sent++;
    endtask

    // Write max_queue once the block is idle, then read it back
    task automatic set_max_queue(input logic [5:0] value);
        logic [31:0] rd;
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_QUEUE_ADDR;
        pwdata  <= {26'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.max_queue = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        if (rd !== {26'd0, value})
        begin
            $display("%0t: max_queue readback mismatch, expected %0h, got %0h",
                     $time, {26'd0, value}, rd);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_burst();
        int n;
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        repeat (n) send_item(mk_other(MODE_QUEUE, $urandom));
    endtask

    // Walk a full handshake, then mix articles, flushes and feed replies
    task automatic run_session();
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 1))
                send_item(mk_peer(LK_NODATA, 10'($urandom_range(0, 1023)), 1'b0, 1'($urandom)));
            else
                send_item(mk_peer(line_kind_t'($urandom_range(0, 3)),
                                  10'($urandom_range(0, 1023)), 1'b1, 1'($urandom)));
        end
        if ($urandom_range(0, 4) == 0)
            send_item(mk_peer(LK_STATUS, 10'($urandom_range(0, 1023)), 1'b0, 1'($urandom)));
        send_item(mk_peer(LK_STATUS, CODE_200, 1'b0, 1'($urandom)));
        send_item(mk_peer(LK_STATUS, pick_mode_code(), 1'b0, 1'($urandom)));
        send_item(mk_peer(LK_STATUS, pick_feed_code(), 1'b0, 1'($urandom)));
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 5))
                0, 1: queue_burst();
                2:
                begin
                    queue_burst();
                    send_item(mk_other(MODE_FLUSH, $urandom));
                end
                3: send_item(mk_other(MODE_FLUSH, $urandom));
                4: send_item(mk_peer(LK_STATUS, pick_feed_code(), 1'b0, 1'($urandom)));
                default: send_item(mk_peer(line_kind_t'($urandom_range(1, 2)),
                                           10'($urandom_range(0, 1023)), 1'b0, 1'($urandom)));
            endcase
        end
        send_item(mk_other(MODE_FLUSH, $urandom));
    endtask

    // Send unstructured transactions, including the unused mode
    task automatic run_noise();
        feed_item_t it;
        repeat ($urandom_range(1, 6))
        begin
            it = mk_other(mode_t'($urandom_range(0, 3)), $urandom);
            it.tmo = ($urandom_range(0, 3) == 0);
            send_item(it);
        end
    endtask

    initial
    begin
        int cfg_phase;
        int next_cfg;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        mode         <= MODE_NONE;
        line_kind    <= LK_STATUS;
        status_code  <= '0;
        read_timeout <= 1'b0;
        read_error   <= 1'b0;
        article_in   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_max_queue(6'd63);

        // Directed: walk the handshake, codes at the edges, flush in both modes
        gap_pct = 20;
        send_item(mk_peer(LK_STATUS, 10'd999, 1'b0, 1'b0));
        send_item(mk_peer(LK_BLANK, 10'd0, 1'b0, 1'b0));
        send_item(mk_peer(LK_TEXT, 10'd1023, 1'b0, 1'b1));
        send_item(mk_peer(LK_STATUS, CODE_200, 1'b0, 1'b0));
        send_item(mk_peer(LK_STATUS, CODE_203, 1'b0, 1'b0));
        send_item(mk_peer(LK_STATUS, CODE_238, 1'b0, 1'b0));
        send_item(mk_other(MODE_QUEUE, 32'hFFFF_FFFF));
        send_item(mk_other(MODE_QUEUE, 32'h0000_0000));
        send_item(mk_other(MODE_FLUSH, $urandom));
        send_item(mk_peer(LK_STATUS, CODE_400, 1'b0, 1'b0));
        send_item(mk_peer(LK_STATUS, CODE_480, 1'b0, 1'b0));
        send_item(mk_peer(LK_STATUS, 10'd1023, 1'b0, 1'b0));
        send_item(mk_peer(LK_STATUS, 10'd550, 1'b0, 1'b0));
        send_item(mk_peer(LK_STATUS, CODE_239, 1'b0, 1'b0));
        send_item(mk_peer(LK_NODATA, 10'd0, 1'b0, 1'b0));
        send_item(mk_other(MODE_NONE, $urandom));
        send_item(mk_peer(LK_STATUS, CODE_200, 1'b0, 1'b0));
        send_item(mk_peer(LK_STATUS, CODE_500, 1'b0, 1'b0));
        send_item(mk_other(MODE_QUEUE, 32'hA5A5_5A5A));
        send_item(mk_other(MODE_QUEUE, 32'h5A5A_A5A5));
        send_item(mk_other(MODE_FLUSH, $urandom));
        send_item(mk_peer(LK_STATUS, CODE_200, 1'b1, 1'b1));
        send_item(mk_other(MODE_FLUSH, $urandom));
        send_item(mk_peer(LK_STATUS, CODE_200, 1'b0, 1'b1));
        send_item(mk_peer(LK_STATUS, 10'd0, 1'b0, 1'b0));

        // Random: mostly full sessions, some noise, max_queue changed between phases
        sent = 0;
        cfg_phase = 0;
        next_cfg = CFG_EVERY;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_cfg)
            begin
                case (cfg_phase % 4)
                    0: set_max_queue(6'd0);
                    1: set_max_queue(6'($urandom_range(1, 62)));
                    2: set_max_queue(6'd63);
                    default: set_max_queue(6'($urandom_range(0, 63)));
                endcase
                cfg_phase++;
                next_cfg = sent + CFG_EVERY;
            end
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            if ($urandom_range(0, 3) != 0)
                run_session();
            else
                run_noise();
        end

        // Drain and report
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (sb.errors == 0)
            $display("news_feed_handshake_engine regression: pass");
        else
            $display("news_feed_handshake_engine regression: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/nfhe_pkg.sv
sv/nfhe_front.sv
sv/nfhe_cmd_fifo.sv
sv/nfhe_back.sv
sv/news_feed_handshake_engine.sv
tb/tb.sv
